/* rtl/omni_camera_point_projection_top_defines.svh */
// Assertion macros shared by the omnidirectional projection RTL.
`ifndef OMNI_CAMERA_POINT_PROJECTION_TOP_DEFINES_SVH
`define OMNI_CAMERA_POINT_PROJECTION_TOP_DEFINES_SVH
`ifndef SYNTH
// Implication in the same cycle, disabled during reset.
`define OCCP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("occp assertion failed");
// Implication into the next cycle, disabled during reset.
`define OCCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("occp assertion failed");
// Condition that must never hold, disabled during reset.
`define OCCP_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("occp assertion failed");
`else
`define OCCP_ASSERT_IMP(lbl, ante, cons)
`define OCCP_ASSERT_NEXT(lbl, ante, cons)
`define OCCP_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/occp_pkg.sv */
// Types, constants and helper functions of the omnidirectional projection block.
`default_nettype none
package occp_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 64;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW_0     = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW_1     = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ROT_ROW_2     = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANS_XY      = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANS_Z       = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FOCAL         = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL     = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SKEW_XI       = 4'd7;

	// Reset values: identity rotation and unit focal lengths.
	localparam logic [62:0] ROT_ROW_0_RST = 63'h0000_0000_0008_0000;
	localparam logic [62:0] ROT_ROW_1_RST = 63'h0000_0100_0000_0000;
	localparam logic [62:0] ROT_ROW_2_RST = 63'h2000_0000_0000_0000;
	localparam logic [63:0] FOCAL_RST     = 64'h0001_0000_0001_0000;

	// Largest quotient magnitude kept before the offset is added.
	localparam logic [40:0] QMAG_LIMIT = 41'h100_0000_0000;

	typedef logic [2:0][31:0] cam_t;

	typedef struct packed {
		logic [2:0][2:0][20:0] rot;
		logic [2:0][31:0]      trans;
		logic [31:0]           fx;
		logic [31:0]           fy;
		logic [31:0]           cx;
		logic [31:0]           cy;
		logic [31:0]           skew;
		logic [31:0]           xi;
	} cfg_t;

	// One classified word handed from the front end to the dividers.
	typedef struct packed {
		logic        invalid;
		logic        u_neg;
		logic [63:0] u_mag;
		logic        v_neg;
		logic [63:0] v_mag;
		logic [63:0] d_mag;
	} job_t;

	// Saturate a signed value to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Magnitude of a signed value known to stay below 2^64.
	function automatic logic [63:0] mag64(input logic signed [65:0] v);
		logic signed [65:0] n;
		n = v[65] ? -v : v;
		return n[63:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/occp_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a side payload.
`default_nettype none
module occp_sqrt import occp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [63:0] in_rad,
	input  cam_t        in_side,
	output logic        out_vld,
	output logic [31:0] out_root,
	output cam_t        out_side
);

	localparam int STEPS = 32;

	logic        vld_s  [STEPS];
	logic [63:0] rad_s  [STEPS];
	logic [32:0] rem_s  [STEPS];
	logic [31:0] root_s [STEPS];
	cam_t        side_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic        cur_vld;
		logic [63:0] cur_rad;
		logic [32:0] cur_rem;
		logic [31:0] cur_root;
		cam_t        cur_side;
		logic [34:0] trial;
		logic [34:0] test_v;
		logic        ge;

		if (k == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rad  = in_rad;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld  = vld_s[k-1];
			assign cur_rad  = rad_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_side = side_s[k-1];
		end

		// Bring down two radicand bits and try to subtract 4*root+1.
		assign trial  = {cur_rem, cur_rad[63:62]};
		assign test_v = {1'b0, cur_root, 2'b01};
		assign ge     = trial >= test_v;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= {cur_rad[61:0], 2'b00};
			rem_s[k]  <= ge ? 33'(trial - test_v) : trial[32:0];
			root_s[k] <= {cur_root[30:0], ge};
			side_s[k] <= cur_side;
		end
	end

	assign out_vld  = vld_s[STEPS-1];
	assign out_root = root_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule
`default_nettype wire

/* rtl/occp_front.sv */
// Front end: rotation, translation, norm, denominator and numerators, then classification.
`default_nettype none
module occp_front import occp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  cfg_t               cfg,
	output logic               out_vld,
	output job_t               out_job
);

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	cam_t                   p_s1;
	logic signed [52:0]     prod_s2 [3][3];
	cam_t                   c_s3, c_s4, c_s5;
	logic [2:0][63:0]       sq_s4;
	logic [63:0]            sq_s5;
	logic                   rt_vld;
	logic [31:0]            rt_root;
	cam_t                   rt_side;
	logic signed [47:0]     zc_s6;
	logic signed [64:0]     xr_s6;
	logic signed [63:0]     a_s6, b_s6, nv_s6;
	logic signed [65:0]     den_s7;
	logic signed [64:0]     nu_s7;
	logic signed [63:0]     nv_s7;
	job_t                   job_s8;
	cam_t                   c_next;

	// Valid chain outside the square root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= rt_vld;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Capture the point and form the nine rotation products.
	always_ff @(posedge clk) begin
		p_s1 <= {in_z, in_y, in_x};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[i][j] <= $signed(cfg.rot[i][j]) * $signed(p_s1[j]);
			end
		end
	end

	// Sum each row, round to Q16.16, add the translation and saturate.
	always_comb begin
		logic signed [54:0] acc;
		logic signed [36:0] sum;
		c_next = '0;
		for (int i = 0; i < 3; i++) begin
			acc = 55'(prod_s2[i][0]) + 55'(prod_s2[i][1]) + 55'(prod_s2[i][2])
				+ 55'sd262144;
			sum = 37'($signed(acc[54:19])) + 37'($signed(cfg.trans[i]));
			c_next[i] = sat32(48'(sum));
		end
	end

	// Squares of the camera point, then their sum.
	always_ff @(posedge clk) begin
		c_s3 <= c_next;
		c_s4 <= c_s3;
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= 64'($signed(c_s3[i]) * $signed(c_s3[i]));
		end
		c_s5  <= c_s4;
		sq_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
	end

	occp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s5),
		.in_rad   (sq_s5),
		.in_side  (c_s5),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_side (rt_side)
	);

	// Products for the denominator and both numerators.
	always_ff @(posedge clk) begin
		zc_s6 <= $signed({rt_side[2], 16'h0000});
		xr_s6 <= $signed(cfg.xi) * $signed({1'b0, rt_root});
		a_s6  <= $signed(cfg.fx) * $signed(rt_side[0]);
		b_s6  <= $signed(cfg.skew) * $signed(rt_side[1]);
		nv_s6 <= $signed(cfg.fy) * $signed(rt_side[1]);
	end

	// Exact sums in Q.32.
	always_ff @(posedge clk) begin
		den_s7 <= 66'(zc_s6) + 66'(xr_s6);
		nu_s7  <= 65'(a_s6) + 65'(b_s6);
		nv_s7  <= nv_s6;
	end

	// Classify a zero denominator and split the rest into sign and magnitude.
	always_ff @(posedge clk) begin
		job_s8.invalid <= den_s7 == '0;
		job_s8.d_mag   <= mag64(den_s7);
		job_s8.u_neg   <= nu_s7[64] ^ den_s7[65];
		job_s8.u_mag   <= mag64(66'(nu_s7));
		job_s8.v_neg   <= nv_s7[63] ^ den_s7[65];
		job_s8.v_mag   <= mag64(66'(nv_s7));
	end

	assign out_vld = v_s8;
	assign out_job = job_s8;

endmodule
`default_nettype wire

/* rtl/occp_fifo.sv */
// Short word queue between the front end and the dividers.
`default_nettype none
`include "omni_camera_point_projection_top_defines.svh"
module occp_fifo import occp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_word,
	input  logic pop,
	output job_t pop_word,
	output logic empty,
	output logic full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = count_q == '0;
	assign full     = count_q == CNT_FULL;
	assign pop_word = slot_q[rd_ptr_q];

	// Storage is written only; no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`OCCP_ASSERT_NEVER(a_no_overflow, push && full && !pop)
	`OCCP_ASSERT_NEVER(a_no_underflow, pop && empty)
	`OCCP_ASSERT_NEXT(a_cnt_up, push && !pop, count_q == $past(count_q) + 1'b1)
	`OCCP_ASSERT_NEXT(a_cnt_down, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule
`default_nettype wire

/* rtl/occp_div.sv */
// Pipelined restoring divider for one coordinate, with offset and saturation.
`default_nettype none
module occp_div import occp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic        in_kill,
	input  logic        in_neg,
	input  logic [63:0] in_mag,
	input  logic [63:0] in_dmag,
	input  logic [31:0] in_off,
	output logic        out_vld,
	output logic        out_kill,
	output logic [31:0] out_res
);

	localparam int QBITS = 41;

	logic        vld_s1, kill_s1, neg_s1, ovf_s1;
	logic [63:0] rem_s1, d_s1;
	logic [40:0] nlo_s1;

	logic        vld_s  [QBITS];
	logic        kill_s [QBITS];
	logic        neg_s  [QBITS];
	logic        ovf_s  [QBITS];
	logic [63:0] rem_s  [QBITS];
	logic [63:0] d_s    [QBITS];
	logic [40:0] nlo_s  [QBITS];
	logic [40:0] q_s    [QBITS];

	logic        vld_sf, kill_sf;
	logic [31:0] res_sf;
	logic [40:0] qc;
	logic signed [41:0] qs;

	// Entry: the numerator is mag * 2^16; its bits above 40 form the first
	// partial remainder, and a quotient of 2^41 or more is caught here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		kill_s1 <= in_kill;
		neg_s1  <= in_neg;
		ovf_s1  <= {25'd0, in_mag[63:25]} >= in_dmag;
		rem_s1  <= {25'd0, in_mag[63:25]};
		nlo_s1  <= {in_mag[24:0], 16'h0000};
		d_s1    <= in_dmag;
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		logic        cur_vld, cur_kill, cur_neg, cur_ovf;
		logic [63:0] cur_rem, cur_d;
		logic [40:0] cur_nlo, cur_q;
		logic [64:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign cur_vld  = vld_s1;
			assign cur_kill = kill_s1;
			assign cur_neg  = neg_s1;
			assign cur_ovf  = ovf_s1;
			assign cur_rem  = rem_s1;
			assign cur_d    = d_s1;
			assign cur_nlo  = nlo_s1;
			assign cur_q    = '0;
		end else begin : g_next
			assign cur_vld  = vld_s[k-1];
			assign cur_kill = kill_s[k-1];
			assign cur_neg  = neg_s[k-1];
			assign cur_ovf  = ovf_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_d    = d_s[k-1];
			assign cur_nlo  = nlo_s[k-1];
			assign cur_q    = q_s[k-1];
		end

		// Shift in the next numerator bit and subtract the divisor if it fits.
		assign trial = {cur_rem, cur_nlo[40]};
		assign ge    = trial >= {1'b0, cur_d};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			kill_s[k] <= cur_kill;
			neg_s[k]  <= cur_neg;
			ovf_s[k]  <= cur_ovf;
			d_s[k]    <= cur_d;
			nlo_s[k]  <= {cur_nlo[39:0], 1'b0};
			rem_s[k]  <= ge ? 64'(trial - {1'b0, cur_d}) : trial[63:0];
			q_s[k]    <= {cur_q[39:0], ge};
		end
	end

	// Clamp the magnitude, apply the sign and add the principal point.
	always_comb begin
		qc = (ovf_s[QBITS-1] || q_s[QBITS-1] > QMAG_LIMIT) ? QMAG_LIMIT : q_s[QBITS-1];
		qs = neg_s[QBITS-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf  <= 1'b0;
			kill_sf <= 1'b0;
		end else begin
			vld_sf  <= vld_s[QBITS-1];
			kill_sf <= vld_s[QBITS-1] && kill_s[QBITS-1];
		end
	end

	always_ff @(posedge clk) begin
		res_sf <= kill_s[QBITS-1] ? '0 : sat32(48'(qs) + 48'($signed(in_off)));
	end

	assign out_vld  = vld_sf;
	assign out_kill = kill_sf;
	assign out_res  = res_sf;

endmodule
`default_nettype wire

/* rtl/omni_camera_point_projection_top.sv */
// Top level of the omnidirectional camera point projection block.
//
// One world point (Q16.16) is taken on every clock at which start is high;
// busy stays low, so points may follow each other back to back. Each point
// gives one pixel word on pixel_u, pixel_v and invalid, marked by done for a
// single cycle. The 32-stage square root in the front end and the 41-stage
// quotient pipeline in the back end lie on each point's path; results come
// out in order and cannot be held off. invalid marks a zero denominator, with
// both pixel coordinates forced to zero. Configuration is written through
// wr_en, wr_index and wr_data; the user must write it only while no point is
// in flight, which the block itself does not enforce.
`default_nettype none
`include "omni_camera_point_projection_top_defines.svh"
module omni_camera_point_projection_top import occp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [31:0]     point_x,
	input  logic signed [31:0]     point_y,
	input  logic signed [31:0]     point_z,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output logic                   done,
	output logic signed [31:0]     pixel_u,
	output logic signed [31:0]     pixel_v,
	output logic                   invalid
);

	logic [2:0][62:0] rot_row_q;
	logic [63:0]      trans_xy_q;
	logic [31:0]      trans_z_q;
	logic [63:0]      focal_q;
	logic [63:0]      principal_q;
	logic [63:0]      skew_xi_q;
	cfg_t             cfg;

	logic  front_vld;
	job_t  front_job;
	job_t  queue_word;
	logic  queue_empty;
	logic  queue_full;
	logic  queue_pop;
	logic  u_vld, u_kill, v_vld, v_kill;
	logic [31:0] u_res, v_res;

	// The pipeline takes a word on every cycle.
	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_row_q[0] <= ROT_ROW_0_RST;
			rot_row_q[1] <= ROT_ROW_1_RST;
			rot_row_q[2] <= ROT_ROW_2_RST;
			trans_xy_q   <= '0;
			trans_z_q    <= '0;
			focal_q      <= FOCAL_RST;
			principal_q  <= '0;
			skew_xi_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROT_ROW_0: rot_row_q[0] <= wr_data[62:0];
				REG_ROT_ROW_1: rot_row_q[1] <= wr_data[62:0];
				REG_ROT_ROW_2: rot_row_q[2] <= wr_data[62:0];
				REG_TRANS_XY:  trans_xy_q   <= wr_data;
				REG_TRANS_Z:   trans_z_q    <= wr_data[31:0];
				REG_FOCAL:     focal_q      <= wr_data;
				REG_PRINCIPAL: principal_q  <= wr_data;
				REG_SKEW_XI:   skew_xi_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// Unpack the registers into named fields.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cfg.rot[i][j] = rot_row_q[i][21*j +: 21];
			end
		end
		cfg.trans[0] = trans_xy_q[31:0];
		cfg.trans[1] = trans_xy_q[63:32];
		cfg.trans[2] = trans_z_q;
		cfg.fx       = focal_q[31:0];
		cfg.fy       = focal_q[63:32];
		cfg.cx       = principal_q[31:0];
		cfg.cy       = principal_q[63:32];
		cfg.skew     = skew_xi_q[31:0];
		cfg.xi       = skew_xi_q[63:32];
	end

	occp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.in_x    (point_x),
		.in_y    (point_y),
		.in_z    (point_z),
		.cfg     (cfg),
		.out_vld (front_vld),
		.out_job (front_job)
	);

	occp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_vld),
		.push_word (front_job),
		.pop       (queue_pop),
		.pop_word  (queue_word),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	// The dividers never stall, so a waiting word is taken at once.
	assign queue_pop = !queue_empty;

	occp_div u_div_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (queue_pop),
		.in_kill  (queue_word.invalid),
		.in_neg   (queue_word.u_neg),
		.in_mag   (queue_word.u_mag),
		.in_dmag  (queue_word.d_mag),
		.in_off   (cfg.cx),
		.out_vld  (u_vld),
		.out_kill (u_kill),
		.out_res  (u_res)
	);

	occp_div u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (queue_pop),
		.in_kill  (queue_word.invalid),
		.in_neg   (queue_word.v_neg),
		.in_mag   (queue_word.v_mag),
		.in_dmag  (queue_word.d_mag),
		.in_off   (cfg.cy),
		.out_vld  (v_vld),
		.out_kill (v_kill),
		.out_res  (v_res)
	);

	// Both dividers run in lock step; the u side drives the strobe.
	assign done    = u_vld;
	assign invalid = u_kill;
	assign pixel_u = u_res;
	assign pixel_v = v_res;

	`OCCP_ASSERT_IMP(a_lockstep, 1'b1, u_vld == v_vld && u_kill == v_kill)
	`OCCP_ASSERT_IMP(a_invalid_zero, invalid, done && pixel_u == '0 && pixel_v == '0)
	`OCCP_ASSERT_NEVER(a_queue_room, front_vld && queue_full)

endmodule
`default_nettype wire
